// ===== rtl/stkfy_pkg.sv =====
// stkfy_pkg: shared types and constants for the shuffling stack
// transfer payload structs, mode and status codes, divider sizing
// no dependencies
`default_nettype none

package stkfy_pkg;

   // fixed field widths of the transfer payloads
   localparam int MODE_W   = 2;
   localparam int ITEM_W   = 8;
   localparam int RND_BITS = 31;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // defaults for the top-level parameters
   localparam int DEF_CAPACITY  = 64;
   localparam int DEF_ITEM_BITS = 8;

   // remainder unit: digits of 4 bits, 8 iterations cover the random word
   localparam int DIV_DIGIT = 4;
   localparam int DIV_ITERS = 8;
   localparam int DIV_BITS  = DIV_DIGIT * DIV_ITERS;
   localparam int DIV_CNT_W = $clog2(DIV_ITERS);

   // mode codes
   localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SHUFFLE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [ITEM_W-1:0]   item_in;
      logic [RND_BITS-1:0] random_word;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ITEM_W-1:0]   item_out;
      logic [COUNT_W-1:0]  count_out;
      logic                pass_done;
   } rsp_type;

   // handshake between the sequencer and the remainder unit
   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/stkfy_mem.sv =====
// stkfy_mem: item store, one write port and one read port
// read data registered; no package types used
`default_nettype none

module stkfy_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/stkfy_mod.sv =====
// stkfy_mod: iterative remainder of the random word by a small divisor
// four dividend bits per cycle; uses stkfy_pkg
`default_nettype none

module stkfy_mod import stkfy_pkg::*; #(
   parameter int CW = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [RND_BITS-1:0] dividend,
   input  wire logic [CW-1:0]       divisor,
   output logic                     done,
   output logic      [CW-1:0]       remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic [DIV_BITS-1:0]  dvd_ff, dvd_in;
   logic [CW-1:0]        dsr_ff, dsr_in;
   logic [CW-1:0]        step_rem;
   logic [CW:0]          trial;

   // one restoring digit: four dependent compare-subtract steps
   always_comb begin
      step_rem = rem_ff;
      trial    = '0;
      for (int i = 0; i < DIV_DIGIT; i++) begin
         trial = {step_rem, dvd_ff[DIV_BITS-1-i]};
         if (trial >= {1'b0, dsr_ff}) begin
            trial = trial - {1'b0, dsr_ff};
         end
         step_rem = trial[CW-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = {{(DIV_BITS-RND_BITS){1'b0}}, dividend};
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = step_rem;
         dvd_in = dvd_ff << DIV_DIGIT;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/stack_with_fisher_yates_shuffle_core.sv =====
// stack_with_fisher_yates_shuffle_core: bounded lifo with in-place shuffle
// top level; uses stkfy_pkg, stkfy_mem and stkfy_mod
`default_nettype none

// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_type: mode, item_in, random_word
// rsp_      out        rsp_valid/rsp_stall  rsp_type: status, item_out, count_out, pass_done
//
// push, pop, ignored mode and a shuffle step that ends at once: idle, then response state
// shuffle step that swaps: idle, div, wra, wrb, response; div waits on the remainder unit,
// then the read, write, write sequence runs on the store's single write port
// reset is synchronous and clears count, cursor and orientation; no clearing pass
// a waiting result sits in the output register; a new transfer is taken while it waits,
// and the sequencer holds its next result until rsp_stall drops

module stack_with_fisher_yates_shuffle_core import stkfy_pkg::*; #(
   parameter int CAPACITY  = DEF_CAPACITY,
   parameter int ITEM_BITS = DEF_ITEM_BITS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // address width into the store, and count width (holds CAPACITY itself)
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW:0] CAP_A = (AW+1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_WRA  = 3'd2;
   localparam logic [2:0] ST_WRB  = 3'd3;
   localparam logic [2:0] ST_RESP = 3'd4;

   // the stack is a ring in the store: logical position p (0 = bottom) sits at
   // base + p or base - p depending on the direction bit, so a full reversal
   // only moves base to the old top and flips the direction
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic          dir,
                                          input logic [AW-1:0] pos);
      logic [AW:0] s;
      if (!dir) begin
         s = {1'b0, base} + {1'b0, pos};
         if (s >= CAP_A) begin
            s = s - CAP_A;
         end
      end else begin
         s = {1'b0, base} - {1'b0, pos};
         if (s[AW]) begin
            s = s + CAP_A;
         end
      end
      return s[AW-1:0];
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                active_ff, active_in;
   logic [AW-1:0]       cursor_ff, cursor_in;
   logic [AW-1:0]       base_ff, base_in;
   logic                dir_ff, dir_in;

   // per-item working registers
   logic [AW-1:0]       addr_a_ff, addr_a_in;
   logic [AW-1:0]       addr_b_ff, addr_b_in;
   logic [ITEM_BITS-1:0] tmp_a_ff, tmp_a_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_done_ff, res_done_in;
   logic                res_pop_ff, res_pop_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // store ports
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [ITEM_BITS-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic [ITEM_BITS-1:0] mem_rd_data;

   // remainder unit
   div_ctl_type          div_ctl;
   logic                 div_done_w;
   logic [CW-1:0]        div_divisor;
   logic [CW-1:0]        div_rem;

   logic                 req_xfer;
   logic [CW-1:0]        cnt_m1;
   logic [AW-1:0]        cur_start;
   logic [CW-1:0]        pos_a;
   logic [CW-1:0]        pos_b;
   logic [AW-1:0]        rev_base;
   logic [ITEM_BITS+ITEM_W-1:0] item_in_ext;
   logic [ITEM_BITS+ITEM_W-1:0] item_out_ext;
   logic [CW+COUNT_W-1:0]       count_ext;

   assign req_xfer = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign cnt_m1    = count_ff - 1'b1;
   // cursor: carried during a pass, count-1 at the first step
   assign cur_start = active_ff ? cursor_ff :
                      ((count_ff == '0) ? '0 : cnt_m1[AW-1:0]);
   // top-relative position k lives at logical position count-1-k
   assign pos_a     = cnt_m1 - CW'(cur_start);
   assign pos_b     = cnt_m1 - div_rem;
   assign rev_base  = phys(base_ff, dir_ff, cnt_m1[AW-1:0]);
   assign div_divisor = CW'(cur_start) + 1'b1;

   assign item_in_ext  = {{ITEM_BITS{1'b0}}, req_data.item_in};
   assign item_out_ext = {{ITEM_W{1'b0}}, mem_rd_data};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      active_in     = active_ff;
      cursor_in     = cursor_ff;
      base_in       = base_ff;
      dir_in        = dir_ff;
      addr_a_in     = addr_a_ff;
      addr_b_in     = addr_b_ff;
      tmp_a_in      = tmp_a_ff;
      res_status_in = res_status_ff;
      res_done_in   = res_done_ff;
      res_pop_in    = res_pop_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr_a_ff;
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = addr_a_ff;
      div_ctl       = '0;
      div_ctl.done  = div_done_w;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               res_status_in = STATUS_OK;
               res_done_in   = 1'b0;
               res_pop_in    = 1'b0;
               state_in      = ST_RESP;
               case (req_data.mode)
                  MODE_PUSH: begin
                     if (active_ff) begin
                        res_status_in = STATUS_BUSY;
                     end else if (count_ff == CAP_C) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = phys(base_ff, dir_ff, count_ff[AW-1:0]);
                        mem_wr_data = item_in_ext[ITEM_BITS-1:0];
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  MODE_POP: begin
                     if (active_ff) begin
                        res_status_in = STATUS_BUSY;
                     end else if (count_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        // top entry comes back in the response cycle
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = phys(base_ff, dir_ff, cnt_m1[AW-1:0]);
                        count_in    = cnt_m1;
                        res_pop_in  = 1'b1;
                     end
                  end
                  MODE_SHUFFLE: begin
                     if (cur_start == '0) begin
                        // nothing to swap: reverse and end the pass now
                        if (count_ff != '0) begin
                           base_in = rev_base;
                        end
                        dir_in      = ~dir_ff;
                        active_in   = 1'b0;
                        cursor_in   = '0;
                        res_done_in = 1'b1;
                     end else begin
                        // fetch entry a while the remainder is worked out
                        active_in     = 1'b1;
                        cursor_in     = cur_start;
                        addr_a_in     = phys(base_ff, dir_ff, pos_a[AW-1:0]);
                        mem_rd_en     = 1'b1;
                        mem_rd_addr   = addr_a_in;
                        div_ctl.start = 1'b1;
                        state_in      = ST_DIV;
                     end
                  end
                  default: begin
                     // unused mode: plain ok response
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_ctl.done) begin
               // entry a is still on the read port; fetch entry b
               tmp_a_in    = mem_rd_data;
               addr_b_in   = phys(base_ff, dir_ff, pos_b[AW-1:0]);
               mem_rd_en   = 1'b1;
               mem_rd_addr = addr_b_in;
               state_in    = ST_WRA;
            end
         end
         ST_WRA: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_a_ff;
            mem_wr_data = mem_rd_data;
            state_in    = ST_WRB;
         end
         ST_WRB: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_b_ff;
            mem_wr_data = tmp_a_ff;
            cursor_in   = cursor_ff - 1'b1;
            if (cursor_ff == AW'(1)) begin
               // last swap of the pass: reverse and finish
               base_in     = rev_base;
               dir_in      = ~dir_ff;
               active_in   = 1'b0;
               res_done_in = 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: loads when the previous result has left
   assign count_ext = {{COUNT_W{1'b0}}, count_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_RESP && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.status    = res_status_ff;
         rsp_data_in.item_out  = res_pop_ff ? item_out_ext[ITEM_W-1:0] : '0;
         rsp_data_in.count_out = count_ext[COUNT_W-1:0];
         rsp_data_in.pass_done = res_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         cursor_ff    <= '0;
         base_ff      <= '0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         cursor_ff    <= cursor_in;
         base_ff      <= base_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_a_ff     <= addr_a_in;
      addr_b_ff     <= addr_b_in;
      tmp_a_ff      <= tmp_a_in;
      res_status_ff <= res_status_in;
      res_done_ff   <= res_done_in;
      res_pop_ff    <= res_pop_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   stkfy_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (ITEM_BITS),
      .AW    (AW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   stkfy_mod #(
      .CW (CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_ctl.start),
      .dividend  (req_data.random_word),
      .divisor   (div_divisor),
      .done      (div_done_w),
      .remainder (div_rem)
   );

endmodule

`default_nettype wire
